### rtl/plvp_pkg.sv
package plvp_pkg;
   localparam int LookaheadDef  = 40;
   localparam int CoordWidthDef = 16;
   localparam int IdxW = 16;
   localparam int SpdW = 8;
   localparam int VelW = 17;
   localparam logic [1:0] RegPathLength = 2'd0;
   localparam logic [1:0] RegStartSpeed = 2'd1;
   localparam logic [1:0] RegEndSpeed   = 2'd2;
   localparam logic [1:0] RegMaxSpeed   = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic       start;      // begin one result computation
      logic       is_flush;   // target is newest point (doubled difference)
      logic       last;       // flag for this result
   } plvp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;             // result computed and held
   } plvp_sts_type;
endpackage

### rtl/plvp_ram.sv
module plvp_ram #(
   parameter int Width = 32,
   parameter int Depth = 41
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/plvp_datapath.sv
// Velocity arithmetic for one result: speed divide, then square root and two divides unless the direction is zero.
module plvp_datapath #(
   parameter int CoordWidth = plvp_pkg::CoordWidthDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  plvp_pkg::plvp_cmd_type      cmd,
   output plvp_pkg::plvp_sts_type      sts,
   input  logic signed [CoordWidth-1:0] tgt_x,
   input  logic signed [CoordWidth-1:0] tgt_y,
   input  logic signed [CoordWidth-1:0] prv_x,
   input  logic signed [CoordWidth-1:0] prv_y,
   input  logic signed [CoordWidth-1:0] pnt_x,
   input  logic signed [CoordWidth-1:0] pnt_y,
   input  logic [plvp_pkg::IdxW-1:0]   index,
   input  logic [plvp_pkg::IdxW-1:0]   path_len,
   input  logic [plvp_pkg::SpdW-1:0]   start_speed,
   input  logic [plvp_pkg::SpdW-1:0]   end_speed,
   input  logic [plvp_pkg::SpdW-1:0]   max_speed,
   output logic signed [plvp_pkg::VelW-1:0] vel_x,
   output logic signed [plvp_pkg::VelW-1:0] vel_y,
   output logic [plvp_pkg::IdxW-1:0]   vel_index,
   output logic                        vel_last
);
   localparam int DW = CoordWidth + 2;    // doubled difference
   localparam int MW = DW - 1;            // magnitude width
   localparam int NumW = 42;              // 256*(255*65535)+L/2 fits
   localparam int QW = 60;                // quotient / dividend width

   typedef enum logic [3:0] {
      S_IDLE, S_NORM, S_SPD, S_SQ, S_SQRT, S_DX, S_DY, S_DONE
   } ph_type;

   ph_type                ph_ff;
   logic [6:0]            cnt_ff;
   logic                  nx_ff, ny_ff, zero_ff;
   logic [MW-1:0]         ax_ff, ay_ff;
   logic [NumW-1:0]       rem_ff;     // generic remainder
   logic [QW-1:0]         num_ff;     // dividend being shifted in
   logic [QW-1:0]         quo_ff;
   logic [QW-1:0]         den_ff;
   logic [16:0]           v_ff;
   logic [63:0]           sq_n_ff, sq_res_ff, sq_bit_ff;
   logic [31:0]           s_ff;
   logic [16:0]           ox_ff;
   logic [plvp_pkg::IdxW-1:0] idx_ff;
   logic                  last_ff;

   logic signed [DW-1:0]  dx_c, dy_c;
   logic [plvp_pkg::IdxW-1:0] len_c, ii_c;
   logic [QW:0]           trial_c;
   logic [QW-1:0]         rem_sh_c;
   logic [63:0]           sq_t_c;
   logic [31:0]           ax32_c, ay32_c;

   always_comb begin
      if (cmd.is_flush) begin
         dx_c = DW'(tgt_x) - DW'(pnt_x);
         dy_c = DW'(tgt_y) - DW'(pnt_y);
         dx_c = dx_c <<< 1;
         dy_c = dy_c <<< 1;
      end else begin
         dx_c = DW'(prv_x) + DW'(tgt_x) - (DW'(pnt_x) <<< 1);
         dy_c = DW'(prv_y) + DW'(tgt_y) - (DW'(pnt_y) <<< 1);
      end
      len_c = (path_len == '0) ? plvp_pkg::IdxW'(1) : path_len;
      ii_c  = (index > len_c) ? len_c : index;
      // restoring divide step; remainder stays below the divisor
      rem_sh_c = QW'({rem_ff, num_ff[QW-1]});
      trial_c  = {1'b0, rem_sh_c} - {1'b0, den_ff};
      sq_t_c   = sq_res_ff + sq_bit_ff;
      ax32_c   = 32'(ax_ff);
      ay32_c   = 32'(ay_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= S_IDLE;
      end else begin
         case (ph_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  nx_ff   <= dx_c[DW-1];
                  ny_ff   <= dy_c[DW-1];
                  ax_ff   <= MW'(dx_c[DW-1] ? -dx_c : dx_c);
                  ay_ff   <= MW'(dy_c[DW-1] ? -dy_c : dy_c);
                  zero_ff <= (dx_c == '0) && (dy_c == '0);
                  idx_ff  <= index;
                  last_ff <= cmd.last;
                  // speed numerator, rounding included
                  num_ff  <= QW'({24'(start_speed) * 24'(len_c - ii_c)
                                  + 24'(end_speed) * 24'(ii_c), 8'd0})
                             + QW'(len_c >> 1);
                  den_ff  <= QW'(len_c);
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  cnt_ff  <= 7'(QW);
                  ph_ff   <= S_NORM;
               end
            end
            S_NORM: begin
               // shift magnitudes together below 2^16
               if (((ax_ff | ay_ff) >> 16) != '0) begin
                  ax_ff <= ax_ff >> 1;
                  ay_ff <= ay_ff >> 1;
               end else begin
                  ph_ff <= S_SPD;
               end
            end
            S_SPD, S_DX, S_DY: begin
               if (ph_ff == S_DX && cnt_ff == 7'd1) begin
                  // x quotient complete: keep it and load the y divide
                  ox_ff  <= 17'(trial_c[QW] ? {quo_ff[QW-2:0], 1'b0}
                                            : {quo_ff[QW-2:0], 1'b1});
                  num_ff <= QW'({34'(v_ff) * 34'(ay_ff), 14'd0}) + QW'(s_ff >> 1);
                  rem_ff <= '0;
                  quo_ff <= '0;
                  cnt_ff <= 7'(QW);
                  ph_ff  <= S_DY;
               end else begin
                  num_ff <= num_ff << 1;
                  if (!trial_c[QW]) begin
                     rem_ff <= NumW'(trial_c[QW-1:0]);
                     quo_ff <= {quo_ff[QW-2:0], 1'b1};
                  end else begin
                     rem_ff <= NumW'(rem_sh_c);
                     quo_ff <= {quo_ff[QW-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 7'd1;
                  if (cnt_ff == 7'd1) begin
                     ph_ff <= (ph_ff == S_SPD) ? S_SQ : S_DONE;
                  end
               end
            end
            S_SQ: begin
               if (quo_ff < QW'({max_speed, 8'd0})) begin
                  v_ff <= 17'(quo_ff);
               end else begin
                  v_ff <= {1'b0, max_speed, 8'd0};
               end
               sq_n_ff   <= (64'(ax32_c * ax32_c) + 64'(ay32_c * ay32_c)) << 28;
               sq_res_ff <= '0;
               sq_bit_ff <= 64'd1 << 62;
               ph_ff     <= zero_ff ? S_DONE : S_SQRT;
            end
            S_SQRT: begin
               if (sq_bit_ff == '0) begin
                  s_ff   <= 32'(sq_res_ff);
                  num_ff <= QW'({34'(v_ff) * 34'(ax_ff), 14'd0})
                            + QW'(sq_res_ff[31:1]);
                  den_ff <= QW'(sq_res_ff);
                  rem_ff <= '0;
                  quo_ff <= '0;
                  cnt_ff <= 7'(QW);
                  ph_ff  <= S_DX;
               end else begin
                  if (sq_n_ff >= sq_t_c) begin
                     sq_n_ff   <= sq_n_ff - sq_t_c;
                     sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
                  end else begin
                     sq_res_ff <= sq_res_ff >> 1;
                  end
                  sq_bit_ff <= sq_bit_ff >> 2;
               end
            end
            S_DONE: begin
               if (zero_ff) begin
                  vel_x <= signed'(v_ff);
                  vel_y <= '0;
               end else begin
                  vel_x <= signed'(nx_ff ? 17'(-ox_ff) : ox_ff);
                  vel_y <= signed'(ny_ff ? 17'(-quo_ff[16:0]) : quo_ff[16:0]);
               end
               vel_index <= idx_ff;
               vel_last  <= last_ff;
               ph_ff     <= S_IDLE;
            end
            default: begin
               ph_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign sts.done = (ph_ff == S_DONE);
endmodule

### rtl/plvp_ctrl.sv
// Sequencer: takes points, writes the ring, issues results, handles flush.
module plvp_ctrl #(
   parameter int Lookahead  = plvp_pkg::LookaheadDef,
   parameter int CoordWidth = plvp_pkg::CoordWidthDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [plvp_pkg::IdxW-1:0]   path_len,
   input  logic signed [CoordWidth-1:0] in_x,
   input  logic signed [CoordWidth-1:0] in_y,
   output logic                        ram_we,
   output logic [$clog2(Lookahead+1)-1:0] ram_wa,
   output logic [$clog2(Lookahead+1)-1:0] ram_ra,
   output logic [plvp_pkg::IdxW-1:0]   index,
   output logic signed [CoordWidth-1:0] new_x,
   output logic signed [CoordWidth-1:0] new_y,
   output logic                        prev_cap,  // latch read as previous point
   output plvp_pkg::plvp_cmd_type      cmd,
   input  plvp_pkg::plvp_sts_type      sts,
   output logic                        rsp_valid,
   input  logic                        rsp_stall
);
   localparam int Depth = Lookahead + 1;
   localparam int AW = $clog2(Depth);

   typedef enum logic [2:0] {
      C_IDLE, C_RDPREV, C_RDPT, C_ISSUE, C_WAIT, C_OUT
   } st_type;

   st_type                    st_ff;
   logic [plvp_pkg::IdxW-1:0] seen_ff;     // points taken this path
   logic [AW-1:0]             slot_ff;     // ring slot for the next point
   logic [plvp_pkg::IdxW-1:0] idx_ff;      // result index in progress
   logic [AW-1:0]             rslot_ff;
   logic                      last_ff;     // this point ends the path
   logic                      flush_ff;
   logic                      rsp_valid_ff;
   logic signed [CoordWidth-1:0] nx_ff, ny_ff;
   logic [AW-1:0]             ra_ff;
   logic                      pc_ff;
   plvp_pkg::plvp_cmd_type    cmd_ff;
   logic [plvp_pkg::IdxW-1:0] len_c;

   function automatic logic [AW-1:0] inc(input logic [AW-1:0] s);
      return (s == AW'(Depth - 1)) ? '0 : s + AW'(1);
   endfunction
   function automatic logic [AW-1:0] dec(input logic [AW-1:0] s);
      return (s == '0) ? AW'(Depth - 1) : s - AW'(1);
   endfunction

   assign len_c     = (path_len == '0) ? plvp_pkg::IdxW'(1) : path_len;
   assign req_stall = (st_ff != C_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign ram_we    = (st_ff == C_IDLE) && req_valid;
   assign ram_wa    = slot_ff;
   assign ram_ra    = ra_ff;
   assign index     = idx_ff;
   assign new_x     = nx_ff;
   assign new_y     = ny_ff;
   assign prev_cap  = pc_ff;
   assign cmd       = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= C_IDLE;
         seen_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '0;
         pc_ff        <= 1'b0;
      end else begin
         case (st_ff)
            C_IDLE: begin
               if (req_valid) begin
                  nx_ff   <= in_x;
                  ny_ff   <= in_y;
                  last_ff <= (32'(seen_ff) + 32'd1 >= 32'(len_c));
                  if (seen_ff >= plvp_pkg::IdxW'(Lookahead)) begin
                     flush_ff <= 1'b0;
                     idx_ff   <= seen_ff - plvp_pkg::IdxW'(Lookahead);
                     rslot_ff <= inc(slot_ff);   // oldest slot = k-Lookahead
                     ra_ff    <= dec(slot_ff);
                     st_ff    <= C_RDPREV;
                  end else if (32'(seen_ff) + 32'd1 >= 32'(len_c)) begin
                     flush_ff <= 1'b1;
                     idx_ff   <= '0;
                     rslot_ff <= slot_ff - AW'(seen_ff);
                     ra_ff    <= slot_ff - AW'(seen_ff);
                     st_ff    <= C_RDPT;
                  end else begin
                     seen_ff <= seen_ff + plvp_pkg::IdxW'(1);
                  end
                  slot_ff <= inc(slot_ff);
               end
            end
            C_RDPREV: begin
               ra_ff <= rslot_ff;
               pc_ff <= 1'b1;        // latch the previous point read from the ring
               st_ff <= C_RDPT;
            end
            C_RDPT: begin
               pc_ff <= 1'b0;
               st_ff <= C_ISSUE;
            end
            C_ISSUE: begin
               cmd_ff.start    <= 1'b1;
               cmd_ff.is_flush <= flush_ff;
               cmd_ff.last     <= flush_ff ? (idx_ff == seen_ff) : !last_ff;
               st_ff           <= C_WAIT;
            end
            C_WAIT: begin
               cmd_ff.start <= 1'b0;
               if (sts.done) begin
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= C_OUT;
               end
            end
            C_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (flush_ff && idx_ff == seen_ff) begin
                     // path done: next path starts at ring slot 0
                     seen_ff <= '0;
                     slot_ff <= '0;
                     st_ff   <= C_IDLE;
                  end else if (flush_ff || last_ff) begin
                     if (!flush_ff) begin
                        // first flush result follows the lookahead result
                        idx_ff   <= seen_ff - plvp_pkg::IdxW'(Lookahead - 1);
                        rslot_ff <= inc(rslot_ff);
                        ra_ff    <= inc(rslot_ff);
                     end else begin
                        idx_ff   <= idx_ff + plvp_pkg::IdxW'(1);
                        rslot_ff <= inc(rslot_ff);
                        ra_ff    <= inc(rslot_ff);
                     end
                     flush_ff <= 1'b1;
                     st_ff    <= C_RDPT;
                  end else begin
                     seen_ff <= seen_ff + plvp_pkg::IdxW'(1);
                     st_ff   <= C_IDLE;
                  end
               end
            end
            default: begin
               st_ff <= C_IDLE;
            end
         endcase
      end
   end
endmodule

### rtl/path_lookahead_velocity_profile_core.sv
// Lookahead velocity profile.
// Input channel req_*: one waypoint word per handshake (req_valid high,
// req_stall low). Output channel rsp_*: one velocity word per handshake.
// Waypoint i yields its result when waypoint i+LOOKAHEAD is taken; the
// final waypoint of a path (points seen + 1 >= path_length) flushes all
// pending results in index order; rsp_last_of_run marks the final one and
// each result of a non-final waypoint. csr_*: register write port
// (0 path_length, 1 start_speed, 2 end_speed, 3 max_speed), written only
// while idle, a rule on the user that the block does not enforce. Each
// result is computed serially by one shared restoring divider and a
// bit-pair square-root unit: a speed divide, at most one normalising
// shift, the root and two divides; a zero direction skips the root and
// the divides. Each further flushed word is computed only after the one
// before it is taken. Waypoints that give no result are taken back to back.
// While any result is pending the input is stalled; a stalled output word
// holds. Reset clears the point count and loads the register reset values;
// the ring store holds no reset state.
module path_lookahead_velocity_profile_core #(
   parameter int Lookahead  = plvp_pkg::LookaheadDef,
   parameter int CoordWidth = plvp_pkg::CoordWidthDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [CoordWidth-1:0] req_point_x,
   input  logic signed [CoordWidth-1:0] req_point_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [plvp_pkg::VelW-1:0] rsp_vel_x,
   output logic signed [plvp_pkg::VelW-1:0] rsp_vel_y,
   output logic [plvp_pkg::IdxW-1:0]   rsp_point_index,
   output logic                        rsp_last_of_run,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_data
);
   localparam int AW = $clog2(Lookahead + 1);

   logic [15:0] len_ff;
   logic [7:0]  sspd_ff, espd_ff, mspd_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= 16'd1;
         sspd_ff <= '0;
         espd_ff <= '0;
         mspd_ff <= 8'd50;
      end else if (csr_write) begin
         case (csr_index)
            plvp_pkg::RegPathLength: len_ff  <= csr_data;
            plvp_pkg::RegStartSpeed: sspd_ff <= csr_data[7:0];
            plvp_pkg::RegEndSpeed:   espd_ff <= csr_data[7:0];
            plvp_pkg::RegMaxSpeed:   mspd_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   logic                   we, pcap;
   logic [AW-1:0]          wa, ra;
   logic [2*CoordWidth-1:0] rd;
   logic [plvp_pkg::IdxW-1:0] idx;
   logic signed [CoordWidth-1:0] nx, ny, px_ff, py_ff;
   plvp_pkg::plvp_cmd_type cmd;
   plvp_pkg::plvp_sts_type sts;

   plvp_ram #(.Width(2 * CoordWidth), .Depth(Lookahead + 1)) u_ring (
      .clock(clock), .wr_en(we), .wr_addr(wa),
      .wr_data({req_point_x, req_point_y}), .rd_addr(ra), .rd_data(rd)
   );

   // previous point capture
   always_ff @(posedge clock) begin
      if (pcap) begin
         px_ff <= rd[2*CoordWidth-1:CoordWidth];
         py_ff <= rd[CoordWidth-1:0];
      end
   end

   plvp_ctrl #(.Lookahead(Lookahead), .CoordWidth(CoordWidth)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .path_len(len_ff), .in_x(req_point_x), .in_y(req_point_y),
      .ram_we(we), .ram_wa(wa), .ram_ra(ra), .index(idx), .new_x(nx),
      .new_y(ny), .prev_cap(pcap), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
   );

   plvp_datapath #(.CoordWidth(CoordWidth)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .tgt_x(nx), .tgt_y(ny), .prv_x(px_ff), .prv_y(py_ff),
      .pnt_x(rd[2*CoordWidth-1:CoordWidth]), .pnt_y(rd[CoordWidth-1:0]),
      .index(idx), .path_len(len_ff), .start_speed(sspd_ff),
      .end_speed(espd_ff), .max_speed(mspd_ff),
      .vel_x(rsp_vel_x), .vel_y(rsp_vel_y), .vel_index(rsp_point_index),
      .vel_last(rsp_last_of_run)
   );
endmodule

### tb/tb_path_lookahead_velocity_profile_core.sv
`timescale 1ns / 100ps

module tb_path_lookahead_velocity_profile_core;
   localparam int Ahead      = plvp_pkg::LookaheadDef;
   localparam int RingDepth  = Ahead + 1;
   localparam int CycleLimit = 1000000;
   localparam int ItemTarget = 110;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } waypoint_type;

   typedef struct packed {
      logic [plvp_pkg::VelW-1:0] vx;
      logic [plvp_pkg::VelW-1:0] vy;
      logic [plvp_pkg::IdxW-1:0] idx;
      logic                      last;
   } vel_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [plvp_pkg::VelW-1:0] rsp_vel_x, rsp_vel_y;
   logic [plvp_pkg::IdxW-1:0] rsp_point_index;
   logic rsp_last_of_run;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = plvp_pkg::RegPathLength;
   logic [15:0] csr_data = '0;

   path_lookahead_velocity_profile_core dut (.*);

   always #2 clock = ~clock;

   waypoint_type waypoint_q[$];
   vel_word_type vel_expect[$];
   int errors = 0;
   int cycles = 0;
   int sent = 0;
   bit no_idle = 1'b0;

   // shadow copy of the block's state and registers
   longint ring_x[RingDepth];
   longint ring_y[RingDepth];
   int unsigned pts_seen = 0;
   logic [63:0] len_reg = 1, start_reg = 0, end_reg = 0, max_reg = 50;

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // linear speed ramp in Q8.8, capped
   function automatic logic [63:0] ramp_speed(int unsigned i);
      logic [63:0] l, ii, v, cap;
      l = (len_reg == 0) ? 64'd1 : len_reg;
      ii = (i > l) ? l : i;
      v = (256 * (start_reg * (l - ii) + end_reg * ii) + l / 2) / l;
      cap = 256 * max_reg;
      return (v < cap) ? v : cap;
   endfunction

   function automatic void push_velocity(int unsigned i, longint dx, longint dy, bit last);
      logic [63:0] v, ax, ay, s, mx, my;
      vel_word_type w;
      v = ramp_speed(i);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax == 0 && ay == 0) begin
         w.vx = v[plvp_pkg::VelW-1:0];
         w.vy = '0;
      end else begin
         while ((ax | ay) >= 64'h10000) begin
            ax >>= 1;
            ay >>= 1;
         end
         s = int_sqrt((ax * ax + ay * ay) << 28);
         mx = (v * ax * 16384 + s / 2) / s;
         my = (v * ay * 16384 + s / 2) / s;
         if (dx < 0) mx = 0 - mx;
         if (dy < 0) my = 0 - my;
         w.vx = mx[plvp_pkg::VelW-1:0];
         w.vy = my[plvp_pkg::VelW-1:0];
      end
      w.idx = i[plvp_pkg::IdxW-1:0];
      w.last = last;
      vel_expect.insert(vel_expect.size(), w);
   endfunction

   // expected velocity words caused by one accepted waypoint
   function automatic void take_waypoint(logic signed [15:0] x, logic signed [15:0] y);
      int unsigned k, l, first, pi;
      longint px, py;
      bit fin;
      k = pts_seen;
      l = (len_reg == 0) ? 1 : int'(len_reg);
      fin = (k + 1 >= l);
      px = x;
      py = y;
      ring_x[k % RingDepth] = px;
      ring_y[k % RingDepth] = py;
      if (k >= Ahead) begin
         pi = k - Ahead;
         push_velocity(pi, ring_x[(k - 1) % RingDepth] + px - 2 * ring_x[pi % RingDepth],
                       ring_y[(k - 1) % RingDepth] + py - 2 * ring_y[pi % RingDepth], !fin);
      end
      if (!fin) begin
         pts_seen = k + 1;
      end else begin
         first = (k >= Ahead) ? k - Ahead + 1 : 0;
         for (int unsigned i = first; i <= k; i++)
            push_velocity(i, 2 * (px - ring_x[i % RingDepth]),
                          2 * (py - ring_y[i % RingDepth]), i == k);
         pts_seen = 0;
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   // waypoint driver
   int gap_left = 0;
   always @(posedge clock) begin
      waypoint_type w;
      int g;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!(req_valid && req_stall)) begin
         g = gap_left;
         if (req_valid) begin
            take_waypoint(req_point_x, req_point_y);
            g = no_idle ? 0 : $urandom_range(0, 9);
         end
         if (g == 0 && waypoint_q.size() > 0) begin
            w = waypoint_q.pop_front();
            req_valid <= 1'b1;
            req_point_x <= w.x;
            req_point_y <= w.y;
            gap_left <= 0;
         end else begin
            req_valid <= 1'b0;
            gap_left <= (g > 0) ? g - 1 : 0;
         end
      end
   end

   // velocity monitor
   int stall_left = 0;
   always @(posedge clock) begin
      vel_word_type e;
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (vel_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected word for point %0d", rsp_point_index));
         end else begin
            e = vel_expect.pop_front();
            if (rsp_vel_x !== e.vx)
               report_mismatch($sformatf("point %0d vel_x %h, want %h", e.idx, rsp_vel_x, e.vx));
            if (rsp_vel_y !== e.vy)
               report_mismatch($sformatf("point %0d vel_y %h, want %h", e.idx, rsp_vel_y, e.vy));
            if (rsp_point_index !== e.idx)
               report_mismatch($sformatf("point_index %0d, want %0d", rsp_point_index, e.idx));
            if (rsp_last_of_run !== e.last)
               report_mismatch($sformatf("point %0d last_of_run %b, want %b",
                                         e.idx, rsp_last_of_run, e.last));
         end
         n = no_idle ? 0 : $urandom_range(0, 9);
         stall_left <= n;
         rsp_stall <= (n != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic set_profile(int len, int st, int en, int mx);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= plvp_pkg::RegPathLength;
      csr_data <= len[15:0];
      len_reg = len[15:0];
      @(posedge clock);
      csr_index <= plvp_pkg::RegStartSpeed;
      csr_data <= st[15:0];
      start_reg = st[7:0];
      @(posedge clock);
      csr_index <= plvp_pkg::RegEndSpeed;
      csr_data <= en[15:0];
      end_reg = en[7:0];
      @(posedge clock);
      csr_index <= plvp_pkg::RegMaxSpeed;
      csr_data <= mx[15:0];
      max_reg = mx[7:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // wait until every word is out and the block has had time to go quiet
   task automatic settle();
      do @(negedge clock);
      while (waypoint_q.size() != 0 || req_valid || vel_expect.size() != 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic add_point(int x, int y);
      waypoint_type p;
      p.x = x[15:0];
      p.y = y[15:0];
      waypoint_q.insert(waypoint_q.size(), p);
      sent++;
   endtask

   // kind 0: smooth walk, 1: arbitrary coordinates, 2: one repeated point
   task automatic queue_path(int n, int kind);
      int cx, cy;
      cx = $urandom_range(0, 65535) - 32768;
      cy = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < n; i++) begin
         if (kind == 1) begin
            cx = $urandom_range(0, 65535) - 32768;
            cy = $urandom_range(0, 65535) - 32768;
         end else if (kind == 0) begin
            cx += $urandom_range(0, 600) - 300;
            cy += $urandom_range(0, 600) - 300;
            if (cx > 32767) cx = 32767;
            if (cx < -32768) cx = -32768;
            if (cy > 32767) cy = 32767;
            if (cy < -32768) cy = -32768;
         end
         add_point(cx, cy);
      end
   endtask

   initial begin
      int n, pass_no;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // register defaults, single-point path
      add_point(32767, -32768);
      settle();
      // zero path length acts as one
      set_profile(0, 255, 0, 255);
      add_point(-32768, 32767);
      settle();
      // short path spanning the coordinate extremes
      set_profile(3, 200, 10, 100);
      add_point(-32768, -32768);
      add_point(32767, 32767);
      add_point(0, 0);
      settle();
      // point equal to its target
      set_profile(2, 0, 255, 0);
      add_point(5, 5);
      add_point(5, 5);
      settle();
      // path shortened mid-run: indices past the new length clamp the speed
      set_profile(100, 30, 250, 255);
      queue_path(8, 0);
      settle();
      set_profile(4, 30, 250, 255);
      add_point(1000, -1000);
      settle();

      pass_no = 0;
      while (sent < ItemTarget) begin
         n = (pass_no < 2) ? $urandom_range(41, 56) : $urandom_range(1, 12);
         no_idle = (pass_no % 3 == 2);
         case ($urandom_range(0, 3))
            0: set_profile(n, 255, 255, 255);
            1: set_profile(n, 0, 0, 0);
            default: set_profile(n, $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255));
         endcase
         queue_path(n, (pass_no == 1) ? 1 : ($urandom_range(0, 5) == 0 ? 2 : 0));
         settle();
         pass_no++;
      end

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
